### hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, masked while reset is active
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// property checked on every rising edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### hw/rtl/bqcr_pkg.sv
// shared constants for the bayer quad channel reducer
// no dependencies; used by the top level and its checker
`default_nettype none

package bqcr_pkg;

  localparam int DEF_MAX_ROW_WIDTH = 2048;
  localparam int DEF_PIXEL_BITS    = 12;

  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 32;
  localparam int ROW_WIDTH_BITS = 12;
  localparam int SEL_BITS       = 3;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_ROW_WIDTH      = 2'd0;
  localparam logic [1:0] REG_CHANNEL_SELECT = 2'd1;
  localparam logic [1:0] REG_MOSAIC_MODE    = 2'd2;

  localparam logic [SEL_BITS-1:0] SEL_SUM   = 3'd0;
  localparam logic [SEL_BITS-1:0] SEL_RED   = 3'd1;
  localparam logic [SEL_BITS-1:0] SEL_GREEN1 = 3'd2;
  localparam logic [SEL_BITS-1:0] SEL_BLUE  = 3'd3;
  localparam logic [SEL_BITS-1:0] SEL_GREEN2 = 3'd4;

  localparam logic [ROW_WIDTH_BITS-1:0] RST_ROW_WIDTH      = 12'd1280;
  localparam logic [SEL_BITS-1:0]       RST_CHANNEL_SELECT = SEL_SUM;
  localparam logic                      RST_MOSAIC_MODE    = 1'b1;

endpackage

`default_nettype wire

### hw/rtl/bayer_quad_channel_reducer_unit.sv
// top level of the bayer quad channel reducer: config registers, pixel
// counters, line store and result register; uses bqcr_pkg and bqcr_ram
`default_nettype none

// One pixel is accepted every clock cycle unless a held result is stalled by
// out_tready; the result shows up on the output register in the cycle after
// the pixel that causes it. In passthrough mode every pixel gives a result. In
// mosaic mode only the odd-column pixel of an odd row gives one (the quad
// result); all other pixels give none. The line store holds one partial per
// quad, written on the even row and read by the even-column pixel of the odd
// row, so its registered read is ready when the quad's last pixel arrives.
// The rate is set by the single output register: in_tready drops only while
// a result is held and out_tready is low. Unwritten store entries read as
// don't care; there is no clearing pass.
module bayer_quad_channel_reducer_unit #(
  parameter int MAX_ROW_WIDTH = bqcr_pkg::DEF_MAX_ROW_WIDTH,
  parameter int PIXEL_BITS    = bqcr_pkg::DEF_PIXEL_BITS,
  localparam int IN_TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((PIXEL_BITS + 2 + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input stream
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [IN_TDATA_W-1:0]           in_tdata,   // pixel
  input  wire logic                            in_tuser,   // frame_start
  // result stream
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [OUT_TDATA_W-1:0]          out_tdata,  // value
  output      logic                            out_tlast,  // row_end
  // configuration
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [bqcr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [bqcr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output      logic [bqcr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output      logic                            cfg_pready
);

  localparam int DEPTH  = MAX_ROW_WIDTH / 2;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
  localparam int EXT_W  = (COL_W + 1 > bqcr_pkg::ROW_WIDTH_BITS) ?
                          COL_W + 1 : bqcr_pkg::ROW_WIDTH_BITS;
  localparam int PART_W = PIXEL_BITS + 1;
  localparam int VAL_W  = PIXEL_BITS + 2;
  localparam logic [EXT_W-1:0] MAX_EVEN = EXT_W'((MAX_ROW_WIDTH / 2) * 2);

  // configuration registers
  logic [bqcr_pkg::ROW_WIDTH_BITS-1:0] row_width_r;
  logic [bqcr_pkg::SEL_BITS-1:0]       channel_select_r;
  logic                                mosaic_mode_r;
  logic                                cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r      <= bqcr_pkg::RST_ROW_WIDTH;
      channel_select_r <= bqcr_pkg::RST_CHANNEL_SELECT;
      mosaic_mode_r    <= bqcr_pkg::RST_MOSAIC_MODE;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        bqcr_pkg::REG_ROW_WIDTH: begin
          row_width_r <= cfg_pwdata[bqcr_pkg::ROW_WIDTH_BITS-1:0];
        end
        bqcr_pkg::REG_CHANNEL_SELECT: begin
          channel_select_r <= cfg_pwdata[bqcr_pkg::SEL_BITS-1:0];
        end
        bqcr_pkg::REG_MOSAIC_MODE: begin
          mosaic_mode_r <= cfg_pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      bqcr_pkg::REG_ROW_WIDTH:      cfg_prdata = bqcr_pkg::CFG_DATA_W'(row_width_r);
      bqcr_pkg::REG_CHANNEL_SELECT: cfg_prdata = bqcr_pkg::CFG_DATA_W'(channel_select_r);
      bqcr_pkg::REG_MOSAIC_MODE:    cfg_prdata = bqcr_pkg::CFG_DATA_W'(mosaic_mode_r);
      default:                      cfg_prdata = '0;
    endcase
  end

  // effective width: even, at least 2, capped at the line store size
  logic [EXT_W-1:0] width_raw;
  logic [EXT_W-1:0] width_eff;

  always_comb begin
    width_raw = EXT_W'({row_width_r[bqcr_pkg::ROW_WIDTH_BITS-1:1], 1'b0});
    if (width_raw < EXT_W'(2)) begin
      width_eff = EXT_W'(2);
    end else if (width_raw > MAX_EVEN) begin
      width_eff = MAX_EVEN;
    end else begin
      width_eff = width_raw;
    end
  end

  // pixel position state
  logic [COL_W-1:0]      col_r, col_nxt;
  logic                  odd_row_r, odd_row_nxt;
  logic [PIXEL_BITS-1:0] pair_hold_r, pair_hold_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]      value_r, value_nxt;
  logic                  row_end_r, row_end_nxt;

  logic                  in_acc;
  logic [PIXEL_BITS-1:0] px;
  logic [COL_W-1:0]      col;
  logic                  odd_row;
  logic                  last;
  logic [bqcr_pkg::SEL_BITS-1:0] sel;
  logic [AW-1:0]         slot;
  logic                  ram_wr_en;
  logic [PART_W-1:0]     ram_wr_data;
  logic                  ram_rd_en;
  logic [PART_W-1:0]     ram_rd_data;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign px        = in_tdata[PIXEL_BITS-1:0];

  always_comb begin
    col     = in_tuser ? '0 : col_r;
    odd_row = in_tuser ? 1'b0 : odd_row_r;
    if (EXT_W'(col) >= width_eff) begin
      col = '0;
    end
    last = (EXT_W'(col) + EXT_W'(1)) == width_eff;
    sel  = (channel_select_r > bqcr_pkg::SEL_GREEN2) ? bqcr_pkg::SEL_SUM : channel_select_r;
    slot = col[AW:1];

    col_nxt       = col_r;
    odd_row_nxt   = odd_row_r;
    pair_hold_nxt = pair_hold_r;
    out_valid_nxt = out_valid_r && !out_tready;
    value_nxt     = value_r;
    row_end_nxt   = row_end_r;
    ram_wr_en     = 1'b0;
    ram_wr_data   = '0;
    // the even-column pixel fetches the quad's partial for its partner
    ram_rd_en     = in_acc && !col[0];

    if (in_acc) begin
      if (last) begin
        col_nxt     = '0;
        odd_row_nxt = !odd_row;
      end else begin
        col_nxt     = col + COL_W'(1);
        odd_row_nxt = odd_row;
      end

      if (!mosaic_mode_r) begin
        out_valid_nxt = 1'b1;
        value_nxt     = VAL_W'(px);
        row_end_nxt   = last;
      end else if (!col[0]) begin
        pair_hold_nxt = px;
      end else if (!odd_row) begin
        ram_wr_en = 1'b1;
        case (sel)
          bqcr_pkg::SEL_SUM: ram_wr_data = PART_W'(pair_hold_r) + PART_W'(px);
          bqcr_pkg::SEL_RED: ram_wr_data = PART_W'(pair_hold_r);
          default:           ram_wr_data = PART_W'(px);
        endcase
      end else begin
        out_valid_nxt = 1'b1;
        row_end_nxt   = last;
        case (sel)
          bqcr_pkg::SEL_SUM: begin
            value_nxt = VAL_W'(ram_rd_data) + VAL_W'(pair_hold_r) + VAL_W'(px);
          end
          bqcr_pkg::SEL_RED, bqcr_pkg::SEL_GREEN1: value_nxt = VAL_W'(ram_rd_data);
          bqcr_pkg::SEL_BLUE:                      value_nxt = VAL_W'(px);
          default:                                 value_nxt = VAL_W'(pair_hold_r);
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      odd_row_r   <= 1'b0;
      pair_hold_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      odd_row_r   <= odd_row_nxt;
      pair_hold_r <= pair_hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r   <= value_nxt;
    row_end_r <= row_end_nxt;
  end

  bqcr_ram #(
    .WIDTH (PART_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (slot),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (slot),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(value_r);
  assign out_tlast  = row_end_r;

endmodule

`default_nettype wire

### hw/rtl/bqcr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bqcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output      logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### hw/rtl/bqcr_checker.sv
// port-level checks for the bayer quad channel reducer, bound to its top level
// depends on bqcr_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module bqcr_checker #(
  parameter int PIXEL_BITS = bqcr_pkg::DEF_PIXEL_BITS,
  localparam int IN_TDATA_W  = ((PIXEL_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((PIXEL_BITS + 2 + 7) / 8) * 8
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [IN_TDATA_W-1:0]           in_tdata,
  input wire logic                            in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [OUT_TDATA_W-1:0]          out_tdata,
  input wire logic                            out_tlast,
  input wire logic                            cfg_psel,
  input wire logic                            cfg_penable,
  input wire logic                            cfg_pwrite,
  input wire logic [bqcr_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input wire logic [bqcr_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  input wire logic [bqcr_pkg::CFG_DATA_W-1:0] cfg_prdata,
  input wire logic                            cfg_pready
);

  logic unused_in;
  assign unused_in = in_tvalid ^ in_tuser ^ (^in_tdata);

  // an empty output register never holds off the input
  `CHK_ASSERT(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready)

  // a held result does not change while the sink stalls
  `CHK_ASSERT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // reset empties the output register
  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid)

  // a written channel select reads back on the next cycle
  `CHK_ASSERT(a_sel_readback, clk, rst_n, (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[3:2] == bqcr_pkg::REG_CHANNEL_SELECT) ##1 (cfg_paddr[3:2] == bqcr_pkg::REG_CHANNEL_SELECT) |-> cfg_prdata[bqcr_pkg::SEL_BITS-1:0] == $past(cfg_pwdata[bqcr_pkg::SEL_BITS-1:0]))

endmodule

bind bayer_quad_channel_reducer_unit bqcr_checker #(
  .PIXEL_BITS (PIXEL_BITS)
) u_bqcr_checker (.*);

`default_nettype wire

### tb/sv/testbench.sv
// self-checking bench for bayer_quad_channel_reducer_unit: pixel stream in,
// reduced quads or passed pixels out, checked against an in-bench predictor
// depends on bqcr_pkg and the rtl of the unit under test
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W          = bqcr_pkg::DEF_MAX_ROW_WIDTH;
  localparam int STORE_DEPTH    = MAX_W / 2;
  localparam int IN_W           = ((bqcr_pkg::DEF_PIXEL_BITS + 7) / 8) * 8;
  localparam int OUT_W          = ((bqcr_pkg::DEF_PIXEL_BITS + 2 + 7) / 8) * 8;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_LIMIT    = 50;
  localparam int STAGE1_ITEMS   = 480;
  localparam int STAGE2_ITEMS   = 960;

  localparam logic MODE_PASS   = 1'b0;
  localparam logic MODE_MOSAIC = 1'b1;
  // selector codes past green two fall back to the quad sum
  localparam logic [bqcr_pkg::SEL_BITS-1:0] SEL_SPARE_5 = 3'd5;
  localparam logic [bqcr_pkg::SEL_BITS-1:0] SEL_SPARE_6 = 3'd6;
  localparam logic [bqcr_pkg::SEL_BITS-1:0] SEL_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [13:0] value;
    logic        row_end;
  } reduced_t;

  typedef enum {STEP_CFG, STEP_PIX, STEP_PIX_RES, STEP_PIX_NONE} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [1:0]  idx;
    logic [31:0] data;
    logic [11:0] px;
    logic        fs;
    reduced_t    res;
  } step_t;

  typedef struct {
    int                            row_width;
    logic [bqcr_pkg::SEL_BITS-1:0] sel;
    logic                          mode;
    int                            count;
  } setting_t;

  logic clk;
  logic rst_n = 1'b0;

  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;   // pixel
  logic            in_tuser = 1'b0; // frame_start

  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;      // value
  logic             out_tlast;      // row_end

  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [bqcr_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [bqcr_pkg::CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [bqcr_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  bayer_quad_channel_reducer_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predictor state and its copy of the registers
  logic [11:0]                   row_width_reg = bqcr_pkg::RST_ROW_WIDTH;
  logic [bqcr_pkg::SEL_BITS-1:0] channel_sel_reg = bqcr_pkg::RST_CHANNEL_SELECT;
  logic                          mosaic_reg = bqcr_pkg::RST_MOSAIC_MODE;
  logic [12:0]                   quad_partials [STORE_DEPTH];
  bit                            partial_valid [STORE_DEPTH];
  int                            next_col = 0;
  logic                          on_odd_row = 1'b0;
  logic [11:0]                   held_even_px = '0;

  reduced_t expected_reduced [$];

  int n_items = 0;
  int n_results = 0;
  int n_writes = 0;
  int n_settings = 0;
  int n_errors = 0;
  int stage = 0;
  int quiet_cycles = 0;

  function automatic int active_width();
    int w;
    w = int'(row_width_reg) & ~1;
    if (w < 2) w = 2;
    if (w > MAX_W) w = MAX_W & ~1;
    return w;
  endfunction

  // would this pixel, sent without a frame start, touch a store entry never filled
  function automatic bit reads_unwritten();
    int col;
    if (mosaic_reg != MODE_MOSAIC || !on_odd_row) return 1'b0;
    col = (next_col >= active_width()) ? 0 : next_col;
    return !partial_valid[col >> 1];
  endfunction

  function automatic void reduce_pixel(input logic [11:0] px, input logic fs,
                                       output bit produced, output reduced_t res);
    int                            w, col, slot;
    logic [bqcr_pkg::SEL_BITS-1:0] sel;
    logic                          last;
    w = active_width();
    if (fs) begin
      next_col = 0;
      on_odd_row = 1'b0;
    end
    if (next_col >= w) next_col = 0;
    col = next_col;
    last = (col + 1 == w);
    sel = (channel_sel_reg > bqcr_pkg::SEL_GREEN2) ? bqcr_pkg::SEL_SUM : channel_sel_reg;
    slot = (col >> 1) % STORE_DEPTH;
    produced = 1'b0;
    res = '0;
    if (mosaic_reg == MODE_PASS) begin
      res.value = 14'(px);
      res.row_end = last;
      produced = 1'b1;
    end else if ((col & 1) == 0) begin
      held_even_px = px;
    end else if (!on_odd_row) begin
      case (sel)
        bqcr_pkg::SEL_SUM: quad_partials[slot] = 13'(held_even_px) + 13'(px);
        bqcr_pkg::SEL_RED: quad_partials[slot] = 13'(held_even_px);
        default:           quad_partials[slot] = 13'(px);
      endcase
      partial_valid[slot] = 1'b1;
    end else begin
      case (sel)
        bqcr_pkg::SEL_SUM: begin
          res.value = 14'(quad_partials[slot]) + 14'(held_even_px) + 14'(px);
        end
        bqcr_pkg::SEL_RED, bqcr_pkg::SEL_GREEN1: res.value = 14'(quad_partials[slot]);
        bqcr_pkg::SEL_BLUE:                      res.value = 14'(px);
        default:                                 res.value = 14'(held_even_px);
      endcase
      res.row_end = last;
      produced = 1'b1;
    end
    if (last) begin
      next_col = 0;
      on_odd_row = ~on_odd_row;
    end else begin
      next_col = (col + 1) & 'h7FF;
    end
  endfunction

  function automatic step_t cfg_step(input logic [1:0] idx, input logic [31:0] data);
    step_t s;
    s = '{STEP_CFG, idx, data, 12'd0, 1'b0, '0};
    return s;
  endfunction

  function automatic step_t pix_step(input step_kind_t kind, input logic [11:0] px,
                                     input logic fs, input logic [13:0] value,
                                     input logic last);
    step_t s;
    s = '{kind, 2'd0, 32'd0, px, fs, '{value, last}};
    return s;
  endfunction

  // registers change only once the block has nothing left in flight
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    in_tvalid <= 1'b0;
    while (expected_reduced.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= bqcr_pkg::CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      bqcr_pkg::REG_ROW_WIDTH:      row_width_reg = data[11:0];
      bqcr_pkg::REG_CHANNEL_SELECT: channel_sel_reg = data[bqcr_pkg::SEL_BITS-1:0];
      bqcr_pkg::REG_MOSAIC_MODE:    mosaic_reg = data[0];
      default: ;
    endcase
    n_writes++;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic push_pixel(input logic [11:0] px, input logic fs,
                            input step_kind_t kind, input reduced_t typed);
    bit       produced;
    reduced_t got;
    int       gap_pct;
    stage = (n_items < STAGE1_ITEMS) ? 0 : (n_items < STAGE2_ITEMS) ? 1 : 2;
    gap_pct = (stage == 0) ? 34 : (stage == 1) ? 61 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'(px);
    in_tuser <= fs;
    do @(posedge clk); while (!in_tready);
    n_items++;
    reduce_pixel(px, fs, produced, got);
    if (kind == STEP_PIX_RES) expected_reduced.push_back(typed);
    else if (kind == STEP_PIX && produced) expected_reduced.push_back(got);
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= ((stage == 0) ? 61 : (stage == 1) ? 34 : 0));
  end

  always @(posedge clk) begin
    reduced_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_reduced.size() == 0) begin
        n_errors++;
        if (n_errors <= PRINT_LIMIT)
          $display("%0t: result with nothing expected: value %0d row_end %b",
                   $time, out_tdata, out_tlast);
      end else begin
        want = expected_reduced.pop_front();
        if (out_tdata !== OUT_W'(want.value)) begin
          n_errors++;
          if (n_errors <= PRINT_LIMIT)
            $display("%0t: value mismatch: expected %0d, got %0d",
                     $time, want.value, out_tdata);
        end
        if (out_tlast !== want.row_end) begin
          n_errors++;
          if (n_errors <= PRINT_LIMIT)
            $display("%0t: row_end mismatch: expected %b, got %b",
                     $time, want.row_end, out_tlast);
        end
      end
    end
  end

  // no handshake of any kind for too long means the block hung
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, expected_reduced.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    step_t       directed [$];
    setting_t    settings [$];
    logic [11:0] px;
    logic        fs;
    int          pick;

    foreach (partial_valid[i]) partial_valid[i] = 1'b0;

    // full-scale frame then an all-zero frame on 4-pixel rows
    directed.push_back(cfg_step(bqcr_pkg::REG_ROW_WIDTH, 32'd4));
    directed.push_back(cfg_step(bqcr_pkg::REG_CHANNEL_SELECT, 32'(bqcr_pkg::SEL_SUM)));
    directed.push_back(cfg_step(bqcr_pkg::REG_MOSAIC_MODE, 32'(MODE_MOSAIC)));
    directed.push_back(pix_step(STEP_PIX_NONE, 12'hFFF, 1'b1, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX_NONE, 12'hFFF, 1'b0, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX_NONE, 12'hFFF, 1'b0, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX_NONE, 12'hFFF, 1'b0, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX_NONE, 12'hFFF, 1'b0, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX_RES, 12'hFFF, 1'b0, 14'd16380, 1'b0));
    directed.push_back(pix_step(STEP_PIX_NONE, 12'hFFF, 1'b0, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX_RES, 12'hFFF, 1'b0, 14'd16380, 1'b1));
    directed.push_back(pix_step(STEP_PIX_NONE, 12'h000, 1'b1, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX, 12'h000, 1'b0, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX, 12'h000, 1'b0, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX, 12'h000, 1'b0, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX, 12'h000, 1'b0, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX_RES, 12'h000, 1'b0, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX, 12'h000, 1'b0, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX_RES, 12'h000, 1'b0, 14'd0, 1'b1));
    // passthrough with the width past the cap
    directed.push_back(cfg_step(bqcr_pkg::REG_MOSAIC_MODE, 32'(MODE_PASS)));
    directed.push_back(cfg_step(bqcr_pkg::REG_ROW_WIDTH, 32'd4095));
    directed.push_back(pix_step(STEP_PIX_RES, 12'h000, 1'b1, 14'd0, 1'b0));
    directed.push_back(pix_step(STEP_PIX_RES, 12'hFFF, 1'b0, 14'd4095, 1'b0));

    settings.push_back('{6,    bqcr_pkg::SEL_SUM,    MODE_MOSAIC, 140});
    settings.push_back('{2,    bqcr_pkg::SEL_RED,    MODE_MOSAIC, 80});
    settings.push_back('{10,   bqcr_pkg::SEL_GREEN1, MODE_MOSAIC, 140});
    settings.push_back('{130,  SEL_SPARE_7,          MODE_PASS,   300});
    settings.push_back('{1,    bqcr_pkg::SEL_BLUE,   MODE_MOSAIC, 80});
    settings.push_back('{0,    bqcr_pkg::SEL_GREEN2, MODE_MOSAIC, 80});
    settings.push_back('{8,    SEL_SPARE_5,          MODE_MOSAIC, 100});
    settings.push_back('{7,    SEL_SPARE_6,          MODE_PASS,   60});
    settings.push_back('{12,   SEL_SPARE_7,          MODE_MOSAIC, 100});
    settings.push_back('{16,   bqcr_pkg::SEL_SUM,    MODE_MOSAIC, 200});
    settings.push_back('{2048, bqcr_pkg::SEL_GREEN2, MODE_MOSAIC, 150});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == STEP_CFG) begin
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        push_pixel(directed[i].px, directed[i].fs, directed[i].kind, directed[i].res);
      end
    end
    n_settings++;

    // state carries across settings, so each change lands mid-frame
    foreach (settings[p]) begin
      write_reg(bqcr_pkg::REG_ROW_WIDTH, 32'(settings[p].row_width));
      write_reg(bqcr_pkg::REG_CHANNEL_SELECT, 32'(settings[p].sel));
      write_reg(bqcr_pkg::REG_MOSAIC_MODE, 32'(settings[p].mode));
      n_settings++;
      for (int k = 0; k < settings[p].count; k++) begin
        fs = (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 2);
        if (!fs && reads_unwritten()) fs = 1'b1;
        pick = $urandom_range(9);
        if (pick == 0) px = 12'h000;
        else if (pick == 1) px = 12'hFFF;
        else px = 12'($urandom_range(4095));
        push_pixel(px, fs, STEP_PIX, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (expected_reduced.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d pixels through %0d register settings (%0d writes)",
             n_items, n_settings, n_writes);
    $display("checked %0d results, %0d mismatches", n_results, n_errors);
    if (n_errors == 0 && expected_reduced.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
+incdir+hw/rtl
hw/rtl/bqcr_pkg.sv
hw/rtl/bqcr_ram.sv
hw/rtl/bayer_quad_channel_reducer_unit.sv
hw/rtl/bqcr_checker.sv
tb/sv/testbench.sv
